@@ rtl/multi_stack_shared_memory_defines.svh @@
// assertion macros used by the datapath
`ifndef MULTI_STACK_SHARED_MEMORY_DEFINES_SVH
`define MULTI_STACK_SHARED_MEMORY_DEFINES_SVH

`ifndef SYNTHESIS
`define MSSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define MSSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MSSM_ASSERT(lbl, prop, msg)
`define MSSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/mssm_pkg.sv @@
`timescale 1ns / 1ps

package mssm_pkg;

    localparam int DATA_W           = 32;
    localparam int CAP_W            = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam int MAX_DEPTH_DEF    = 64;
    localparam int NUM_STACKS_DEF   = 3;
    localparam int SEL_W            = 2;
    localparam int FUNC_W           = 2;
    localparam int IN_TUSER_W       = FUNC_W + SEL_W;
    localparam int IN_TDATA_W       = DATA_W;
    localparam int OUT_TDATA_W      = 40;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_TOP  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // lowest bits last: top_data sits at bit 0
    typedef struct packed {
        logic              now_full;
        logic              now_empty;
        t_status           status;
        logic [DATA_W-1:0] top_data;
    } t_result;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic take;
        logic load_now;
        logic load_read;
    } t_cmd;

    typedef struct packed {
        logic skid_free;
        logic needs_read;
    } t_sts;

endpackage

@@ rtl/multi_stack_shared_memory.sv @@
`timescale 1ns / 1ps
// channel   direction  width  contents (lowest bit first)
// s_axis    in         4+32   tuser: func, stack_select; tdata: push_data
// m_axis    out        40     tdata: top_data, status, now_empty, now_full, zero pad
// cfg       in         7      per_stack_capacity, written when i_cfg_wr_en is high
//
// push, pop, failed top, unknown operation and unknown stack: result registered into the
// result queue at the accepting edge, and a new word can be taken before that result has left
// a top that reads an entry passes through the read state: the ram read is registered at
// the accepting edge, the result at the edge that ends the read state, and the input is held
// off during the read state, and also while two results wait at the output
// i_rst_n is synchronous, active low: fill counts zero, capacity 64; the entry ram
// is not cleared, so there is no clearing pass after reset
// an output stall never loses or repeats a word: the two-deep result queue absorbs it

module multi_stack_shared_memory #(
    parameter int MAX_STACK_DEPTH = mssm_pkg::MAX_DEPTH_DEF,
    parameter int NUM_STACKS      = mssm_pkg::NUM_STACKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: per_stack_capacity
    input  logic                             i_cfg_wr_en,
    input  logic [mssm_pkg::CAP_W-1:0]       i_cfg_wr_data,
    // operation words in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mssm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // push_data
    input  logic [mssm_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // func, stack_select
    // result words out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // top_data, status, now_empty, now_full, zero pad
    output logic [mssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // command and status between the sequencer and the datapath
    mssm_pkg::t_cmd w_cmd;
    mssm_pkg::t_sts w_sts;

    // sequencer: idle while words arrive, one extra state for a ram read
    mssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // fill counts, entry ram, capacity register and result queue
    mssm_dpath #(
        .MAX_STACK_DEPTH (MAX_STACK_DEPTH),
        .NUM_STACKS      (NUM_STACKS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tuser       (s_axis_tuser),
        .i_tdata       (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_tdata   (m_axis_tdata),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

endmodule

@@ rtl/mssm_ram.sv @@
`timescale 1ns / 1ps

module mssm_ram #(
    parameter int WIDTH = mssm_pkg::DATA_W,
    parameter int DEPTH = mssm_pkg::NUM_STACKS_DEF * mssm_pkg::MAX_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mssm_ctrl.sv @@
`timescale 1ns / 1ps

module mssm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mssm_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output mssm_pkg::t_cmd o_cmd
);

    mssm_pkg::t_state r_state;
    mssm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mssm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mssm_pkg::S_IDLE: begin
                if (i_in_valid && i_sts.skid_free && i_sts.needs_read) begin
                    n_state = mssm_pkg::S_READ;
                end
            end
            mssm_pkg::S_READ: begin
                n_state = mssm_pkg::S_IDLE;
            end
            default: begin
                n_state = mssm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.take      = 1'b0;
        o_cmd.load_now  = 1'b0;
        o_cmd.load_read = 1'b0;
        unique case (r_state)
            mssm_pkg::S_IDLE: begin
                o_in_ready     = i_sts.skid_free;
                o_cmd.take     = i_in_valid && i_sts.skid_free;
                o_cmd.load_now = i_in_valid && i_sts.skid_free && !i_sts.needs_read;
            end
            mssm_pkg::S_READ: begin
                o_cmd.load_read = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/mssm_dpath.sv @@
`timescale 1ns / 1ps
`include "multi_stack_shared_memory_defines.svh"

module mssm_dpath #(
    parameter int MAX_STACK_DEPTH = mssm_pkg::MAX_DEPTH_DEF,
    parameter int NUM_STACKS      = mssm_pkg::NUM_STACKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [mssm_pkg::CAP_W-1:0]       i_cfg_wr_data,
    input  logic [mssm_pkg::IN_TUSER_W-1:0]  i_tuser,
    input  logic [mssm_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [mssm_pkg::OUT_TDATA_W-1:0] o_out_tdata,
    input  mssm_pkg::t_cmd                   i_cmd,
    output mssm_pkg::t_sts                   o_sts
);

    localparam int CW    = $clog2(MAX_STACK_DEPTH + 1);
    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int DEPTH = NUM_STACKS * MAX_STACK_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD_W = mssm_pkg::OUT_TDATA_W - $bits(mssm_pkg::t_result);

    logic [mssm_pkg::CAP_W-1:0]  r_cap;
    logic [CW-1:0]               r_cnt [NUM_STACKS];

    logic [mssm_pkg::FUNC_W-1:0] w_func;
    logic [mssm_pkg::SEL_W-1:0]  w_sel;
    logic                        w_sel_ok;
    logic [SW-1:0]               w_idx;
    logic [mssm_pkg::CAP_W-1:0]  w_cap_lo;
    logic [CW-1:0]               w_cap;
    logic [CW-1:0]               w_cnt;
    logic [CW-1:0]               n_cnt;
    mssm_pkg::t_status           w_status;
    logic                        w_wr_en;
    logic                        w_empty;
    logic                        w_full;
    logic [AW-1:0]               w_base;
    logic [AW-1:0]               w_wr_addr;
    logic [AW-1:0]               w_rd_addr;
    logic [mssm_pkg::DATA_W-1:0] w_rd_data;

    logic                        r_pend_empty;
    logic                        r_pend_full;

    mssm_pkg::t_result           w_res;
    mssm_pkg::t_result           r_q0;
    mssm_pkg::t_result           r_q1;
    mssm_pkg::t_result           n_q0;
    mssm_pkg::t_result           n_q1;
    logic                        r_q0_valid;
    logic                        r_q1_valid;
    logic                        n_q0_valid;
    logic                        n_q1_valid;
    logic                        w_load;
    logic                        w_pop;

    // capacity register, clamped to 1..max depth on use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= mssm_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_cap_lo = (r_cap == '0) ? mssm_pkg::CAP_W'(1) : r_cap;
        if (int'(w_cap_lo) > MAX_STACK_DEPTH) begin
            w_cap = CW'(MAX_STACK_DEPTH);
        end else begin
            w_cap = CW'(w_cap_lo);
        end
    end

    assign w_func   = i_tuser[mssm_pkg::FUNC_W-1:0];
    assign w_sel    = i_tuser[mssm_pkg::IN_TUSER_W-1:mssm_pkg::FUNC_W];
    assign w_sel_ok = int'(w_sel) < NUM_STACKS;
    assign w_idx    = SW'(w_sel);
    assign w_cnt    = w_sel_ok ? r_cnt[w_idx] : '0;

    always_comb begin
        n_cnt    = w_cnt;
        w_status = mssm_pkg::ST_OK;
        w_wr_en  = 1'b0;
        if (w_sel_ok) begin
            unique case (w_func)
                mssm_pkg::FN_PUSH: begin
                    if (w_cnt >= w_cap) begin
                        w_status = mssm_pkg::ST_FULL;
                    end else begin
                        n_cnt   = w_cnt + CW'(1);
                        w_wr_en = 1'b1;
                    end
                end
                mssm_pkg::FN_POP: begin
                    if (w_cnt == '0) begin
                        w_status = mssm_pkg::ST_EMPTY;
                    end else begin
                        n_cnt = w_cnt - CW'(1);
                    end
                end
                mssm_pkg::FN_TOP: begin
                    if (w_cnt == '0) begin
                        w_status = mssm_pkg::ST_EMPTY;
                    end
                end
                default: begin
                    n_cnt = w_cnt;
                end
            endcase
        end
    end

    assign w_empty = w_sel_ok ? (n_cnt == '0) : 1'b1;
    assign w_full  = w_sel_ok ? (n_cnt >= w_cap) : 1'b0;

    assign o_sts.needs_read = w_sel_ok && (w_func == mssm_pkg::FN_TOP) && (w_cnt != '0);
    assign o_sts.skid_free  = !r_q1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.take && w_sel_ok) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                if (w_idx == SW'(i)) begin
                    r_cnt[i] <= n_cnt;
                end
            end
        end
    end

    // slot addresses stay below the store depth even after a capacity change
    assign w_base    = AW'(w_idx) * AW'(w_cap);
    assign w_wr_addr = w_base + AW'(w_cnt);
    assign w_rd_addr = w_base + AW'(w_cnt) - AW'(1);

    mssm_ram #(
        .WIDTH (mssm_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.take && w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_tdata),
        .i_rd_en   (i_cmd.take && o_sts.needs_read),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pend_empty <= w_empty;
            r_pend_full  <= w_full;
        end
    end

    always_comb begin
        if (i_cmd.load_read) begin
            w_res.top_data  = w_rd_data;
            w_res.status    = mssm_pkg::ST_OK;
            w_res.now_empty = r_pend_empty;
            w_res.now_full  = r_pend_full;
        end else begin
            w_res.top_data  = '0;
            w_res.status    = w_status;
            w_res.now_empty = w_empty;
            w_res.now_full  = w_full;
        end
    end

    // two-deep result queue: head drives the output, second slot is the skid
    assign w_load = i_cmd.load_now || i_cmd.load_read;
    assign w_pop  = r_q0_valid && i_out_ready;

    always_comb begin
        n_q0       = r_q0;
        n_q1       = r_q1;
        n_q0_valid = r_q0_valid;
        n_q1_valid = r_q1_valid;
        if (w_pop) begin
            if (r_q1_valid) begin
                n_q0       = r_q1;
                n_q0_valid = 1'b1;
                n_q1       = w_res;
                n_q1_valid = w_load;
            end else begin
                n_q0       = w_res;
                n_q0_valid = w_load;
            end
        end else if (!r_q0_valid) begin
            n_q0       = w_res;
            n_q0_valid = w_load;
        end else if (w_load) begin
            n_q1       = w_res;
            n_q1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0_valid <= 1'b0;
            r_q1_valid <= 1'b0;
        end else begin
            r_q0_valid <= n_q0_valid;
            r_q1_valid <= n_q1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out_valid = r_q0_valid;
    assign o_out_tdata = {{PAD_W{1'b0}}, r_q0};

    `MSSM_ASSERT(a_queue_no_overflow, w_load |-> !(r_q1_valid && !w_pop), "result queue overflow")
    `MSSM_ASSERT(a_skid_behind_head, r_q1_valid |-> r_q0_valid, "skid word without head word")
    `MSSM_ASSERT(a_read_follows_issue, i_cmd.load_read |-> $past(i_cmd.take), "read result without issue")
    `MSSM_ASSERT_ALWAYS(a_take_needs_room, (i_rst_n && i_cmd.take) |-> !r_q1_valid, "item taken with skid full")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import mssm_pkg::*;

    localparam int          STORE_DEPTH   = NUM_STACKS_DEF * MAX_DEPTH_DEF;
    localparam logic [1:0]  FN_UNKNOWN    = 2'd3;   // func code with no operation behind it
    localparam logic [1:0]  SEL_NONE      = 2'd3;   // stack index past the last stack
    localparam int          SETTLE_CYCLES = 6;      // a top that reads the ram passes through an extra read state
    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          NUM_PHASES    = 10;

    // per phase: capacity written, counted words, push share in percent, favoured stack
    localparam int PHASE_CAP   [NUM_PHASES] = '{1, 64, 0, 3, 127, 2, 8, 65, 5, 64};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{100, 200, 100, 120, 150, 100, 120, 100, 110, 150};
    localparam int PHASE_PUSH  [NUM_PHASES] = '{50, 80, 50, 55, 30, 50, 60, 40, 50, 35};
    localparam int PHASE_FOCUS [NUM_PHASES] = '{-1, 1, -1, 0, -1, 2, -1, -1, 1, -1};

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        sel;
        logic [DATA_W-1:0] data;
    } t_op_word;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // push_data
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // func, stack_select
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // top_data, status, now_empty, now_full, pad

    multi_stack_shared_memory dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_op_word pending_ops [$];
    t_result  expected_results [$];
    int       ops_queued   = 0;
    int       ops_accepted = 0;
    int       error_count  = 0;
    int       cycle_count  = 0;
    logic     s_fire       = 1'b0;

    // predicted contents of the block, updated as words are accepted
    logic [CAP_W-1:0]  pred_cap;
    int                pred_cnt [NUM_STACKS_DEF];
    logic [DATA_W-1:0] pred_mem [STORE_DEPTH];

    // stimulus-side view: fill counts and which ram slots were ever written, so that
    // no top is generated against a slot holding nothing
    int gen_cap = MAX_DEPTH_DEF;
    int gen_cnt [NUM_STACKS_DEF] = '{default: 0};
    bit gen_written [STORE_DEPTH] = '{default: 1'b0};

    function automatic int eff_cap(logic [CAP_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DEPTH_DEF)
            return MAX_DEPTH_DEF;
        return int'(raw);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // one operation against the predicted stacks
    function automatic t_result predict_op(logic [1:0] func, logic [1:0] sel,
                                           logic [DATA_W-1:0] data);
        t_result r;
        int      cap;
        int      base;
        int      cnt;
        r           = '0;
        r.status    = ST_OK;
        cap         = eff_cap(pred_cap);
        if (sel >= NUM_STACKS_DEF) begin
            r.now_empty = 1'b1;
            return r;
        end
        base = int'(sel) * cap;
        cnt  = pred_cnt[sel];
        case (func)
            FN_PUSH: begin
                if (cnt >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    pred_mem[base + cnt] = data;
                    cnt++;
                end
            end
            FN_POP: begin
                if (cnt == 0)
                    r.status = ST_EMPTY;
                else
                    cnt--;
            end
            FN_TOP: begin
                if (cnt == 0)
                    r.status = ST_EMPTY;
                else
                    r.top_data = pred_mem[base + cnt - 1];
            end
            default: ;
        endcase
        pred_cnt[sel] = cnt;
        r.now_empty   = (cnt == 0);
        r.now_full    = (cnt >= cap);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // accepted input words feed the predictor; result words are checked in order
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            s_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
            if (!i_rst_n) begin
                pred_cap = CAP_RESET;
                foreach (pred_cnt[k])
                    pred_cnt[k] = 0;
            end else begin
                if (i_cfg_wr_en)
                    pred_cap = i_cfg_wr_data;
                if (s_axis_tvalid && s_axis_tready) begin
                    expected_results.push_back(predict_op(s_axis_tuser[1:0], s_axis_tuser[3:2],
                                                          s_axis_tdata));
                    ops_accepted++;
                end
                if (m_axis_tvalid && m_axis_tready) begin
                    if (expected_results.size() == 0) begin
                        report_mismatch("unexpected result word", m_axis_tdata, '0);
                    end else begin
                        want = expected_results.pop_front();
                        got  = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                        if (got.top_data !== want.top_data)
                            report_mismatch("top_data", got.top_data, want.top_data);
                        if (got.status !== want.status)
                            report_mismatch("status", got.status, want.status);
                        if (got.now_empty !== want.now_empty)
                            report_mismatch("now_empty", got.now_empty, want.now_empty);
                        if (got.now_full !== want.now_full)
                            report_mismatch("now_full", got.now_full, want.now_full);
                        if (m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)] !== '0)
                            report_mismatch("pad bits", m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)],
                                            '0);
                    end
                end
            end
        end
    end

    // input driver: next word once the current one is taken, with random gaps
    int unsigned in_gap  = 0;
    bit          in_calm = 1'b0;

    always @(negedge i_clk) begin
        t_op_word w;
        if (i_rst_n && (!s_axis_tvalid || s_fire)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                w = pending_ops.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= w.data;
                s_axis_tuser  <= {w.sel, w.func};
                if ($urandom_range(149) == 0)
                    in_calm = !in_calm;
                in_gap = in_calm ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure: random stalls, with stretches of none
    int unsigned out_stall = 0;
    bit          out_calm  = 1'b0;

    always @(negedge i_clk) begin
        int unsigned n;
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(149) == 0)
                out_calm = !out_calm;
            n = (out_calm || $urandom_range(2) != 0) ? 0 : pick_gap();
            if (n > 0) begin
                out_stall = n - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic queue_op(logic [1:0] func, logic [1:0] sel, logic [DATA_W-1:0] data);
        t_op_word w;
        int       base;
        w.func = func;
        w.sel  = sel;
        w.data = data;
        if (sel < NUM_STACKS_DEF) begin
            base = int'(sel) * gen_cap;
            if (func == FN_PUSH && gen_cnt[sel] < gen_cap) begin
                gen_written[base + gen_cnt[sel]] = 1'b1;
                gen_cnt[sel]++;
            end else if (func == FN_POP && gen_cnt[sel] > 0) begin
                gen_cnt[sel]--;
            end
        end
        pending_ops.push_back(w);
        ops_queued++;
    endtask

    task automatic queue_random_op(int push_pct, int focus, output bit counted);
        logic [1:0]        func;
        logic [1:0]        sel;
        logic [DATA_W-1:0] data;
        int                r;
        r = $urandom_range(99);
        if (r < 5)
            sel = SEL_NONE;
        else if (focus >= 0 && r < 60)
            sel = focus[1:0];
        else
            sel = 2'($urandom_range(NUM_STACKS_DEF - 1));
        r = $urandom_range(99);
        if (r < 3)
            func = FN_UNKNOWN;
        else if (r < 3 + push_pct)
            func = FN_PUSH;
        else
            func = $urandom_range(1) ? FN_POP : FN_TOP;
        // a top must not land on a slot that was never written
        if (func == FN_TOP && sel < NUM_STACKS_DEF && gen_cnt[sel] > 0 &&
            !gen_written[int'(sel) * gen_cap + gen_cnt[sel] - 1])
            func = FN_PUSH;
        case ($urandom_range(19))
            0:       data = 32'h7fff_ffff;
            1:       data = 32'h8000_0000;
            2:       data = 32'hffff_ffff;
            3:       data = 32'h0000_0000;
            default: data = $urandom;
        endcase
        queue_op(func, sel, data);
        counted = (sel < NUM_STACKS_DEF);
    endtask

    task automatic wait_idle();
        while (ops_accepted != ops_queued || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        gen_cap = eff_cap(cap);
    endtask

    initial begin
        int n;
        bit counted;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty errors, extreme values, every stack, unknown op and stack
        queue_op(FN_POP,     2'd0,     $urandom);
        queue_op(FN_TOP,     2'd0,     $urandom);
        queue_op(FN_PUSH,    2'd0,     32'h7fff_ffff);
        queue_op(FN_PUSH,    2'd0,     32'h8000_0000);
        queue_op(FN_TOP,     2'd0,     $urandom);
        queue_op(FN_PUSH,    2'd1,     32'hffff_ffff);
        queue_op(FN_PUSH,    2'd2,     32'h0000_0000);
        queue_op(FN_TOP,     2'd1,     $urandom);
        queue_op(FN_TOP,     2'd2,     $urandom);
        queue_op(FN_UNKNOWN, 2'd0,     32'hffff_ffff);
        queue_op(FN_PUSH,    SEL_NONE, 32'hffff_ffff);
        queue_op(FN_POP,     SEL_NONE, $urandom);
        queue_op(FN_TOP,     SEL_NONE, $urandom);
        queue_op(FN_UNKNOWN, SEL_NONE, $urandom);
        queue_op(FN_POP,     2'd0,     $urandom);
        queue_op(FN_TOP,     2'd0,     $urandom);
        queue_op(FN_POP,     2'd0,     $urandom);
        queue_op(FN_POP,     2'd0,     $urandom);
        queue_op(FN_PUSH,    2'd1,     32'h5555_aaaa);
        queue_op(FN_TOP,     2'd1,     $urandom);
        wait_idle();

        // random phases; fill counts carry over each capacity change
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_capacity(PHASE_CAP[p][CAP_W-1:0]);
            n = 0;
            while (n < PHASE_ITEMS[p]) begin
                queue_random_op(PHASE_PUSH[p], PHASE_FOCUS[p], counted);
                if (counted)
                    n++;
            end
            wait_idle();
        end

        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
